// ===== hw/rtl/aps_pkg.sv =====
package aps_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int DIM_W       = 7;
    localparam int POOL_W      = 3;
    localparam int POS_W       = 8;
    localparam int CFG_INDEX_W = 2;
    localparam int MAX_HEIGHT  = 64;

    localparam int DEF_MAX_WIDTH = 64;
    localparam int DEF_MAX_POOL  = 4;

    localparam logic [CFG_INDEX_W-1:0] REG_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_HEIGHT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_POOL   = 2'd2;

    localparam logic [DIM_W-1:0]  RST_WIDTH  = 7'd24;
    localparam logic [DIM_W-1:0]  RST_HEIGHT = 7'd24;
    localparam logic [POOL_W-1:0] RST_POOL   = 3'd2;

    // Controller to datapath.
    typedef struct packed {
        logic take;
        logic accum;
        logic div_step;
        logic out_load;
    } aps_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic emit;
        logic out_free;
    } aps_sts_t;

endpackage

// ===== hw/rtl/aps_ctrl.sv =====
module aps_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  aps_pkg::aps_sts_t sts,
    output aps_pkg::aps_cmd_t cmd
);

    localparam int CNT_W = $clog2(aps_pkg::SAMPLE_W);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_ACCUM,
        ST_DIVIDE,
        ST_FINISH
    } state_t;

    state_t             state_reg;
    logic               ready_reg;
    logic [CNT_W-1:0]   cnt_reg;

    assign s_ready      = ready_reg;
    assign cmd.take     = s_valid && ready_reg;
    assign cmd.accum    = (state_reg == ST_ACCUM);
    assign cmd.div_step = (state_reg == ST_DIVIDE);
    assign cmd.out_load = (state_reg == ST_FINISH) && sts.out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b1;
            cnt_reg   <= '0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid && ready_reg) begin
                        state_reg <= ST_READ;
                        ready_reg <= 1'b0;
                    end
                end
                ST_READ: begin
                    state_reg <= ST_ACCUM;
                end
                ST_ACCUM: begin
                    cnt_reg <= '0;
                    if (sts.emit) begin
                        state_reg <= ST_DIVIDE;
                    end else begin
                        state_reg <= ST_IDLE;
                        ready_reg <= 1'b1;
                    end
                end
                ST_DIVIDE: begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(aps_pkg::SAMPLE_W - 1)) begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    if (sts.out_free) begin
                        state_reg <= ST_IDLE;
                        ready_reg <= 1'b1;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                    ready_reg <= 1'b1;
                end
            endcase
        end
    end

endmodule

// ===== hw/rtl/aps_datapath.sv =====
module aps_datapath #(
    parameter int MAX_WIDTH = aps_pkg::DEF_MAX_WIDTH,
    parameter int MAX_POOL  = aps_pkg::DEF_MAX_POOL
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic [aps_pkg::SAMPLE_W-1:0]         s_sample,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [aps_pkg::SAMPLE_W-1:0]         m_average,
    output logic                                 m_map_done,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [aps_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [aps_pkg::DIM_W-1:0]            cfg_data,
    input  aps_pkg::aps_cmd_t                    cmd,
    output aps_pkg::aps_sts_t                    sts
);

    localparam int SW     = aps_pkg::SAMPLE_W;
    localparam int DW     = aps_pkg::DIM_W;
    localparam int PW     = aps_pkg::POOL_W;
    localparam int QW     = aps_pkg::POS_W;
    localparam int ADDR_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int SUM_W  = SW + $clog2(MAX_POOL * MAX_POOL);
    localparam int DIV_W  = $clog2(MAX_POOL * MAX_POOL + 1);
    localparam int REM_W  = DIV_W + SW;
    localparam int WIDTH_CAP = (MAX_WIDTH < 127) ? MAX_WIDTH : 127;
    localparam int POOL_CAP  = (MAX_POOL < 7) ? MAX_POOL : 7;

    typedef struct packed {
        logic in_win;
        logic first;
        logic last;
        logic map_last;
    } item_t;

    // Configuration
    logic [DW-1:0] width_reg;
    logic [DW-1:0] height_reg;
    logic [PW-1:0] pool_reg;
    logic          cfg_hit;

    // Position tracking
    logic [DW-1:0]     col_reg;
    logic [DW-1:0]     row_reg;
    logic [PW-1:0]     cp_reg;
    logic [PW-1:0]     rp_reg;
    logic [QW-1:0]     cs_reg;
    logic [QW-1:0]     rs_reg;
    logic [ADDR_W-1:0] j_reg;

    // Item in flight
    item_t             item_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [SW-1:0]     sample_reg;
    logic [SUM_W-1:0]  rd_data_reg;
    logic [SUM_W-1:0]  mem [MAX_WIDTH];

    // Divider and output
    logic [REM_W-1:0] rem_reg;
    logic [REM_W-1:0] dsh_reg;
    logic [SW-1:0]    quo_reg;
    logic             done_reg;
    logic             m_valid_reg;
    logic [SW-1:0]    m_average_reg;
    logic             m_map_done_reg;

    logic [DW-1:0]     w_eff;
    logic [DW-1:0]     h_eff;
    logic [PW-1:0]     p_eff;
    logic [2*PW-1:0]   p_sq;
    logic [QW-1:0]     p_ext;
    logic [QW-1:0]     w_ext;
    logic [QW-1:0]     h_ext;
    logic              cp_last;
    logic              rp_last;
    item_t             item_now;
    logic [SUM_W-1:0]  acc_sum;
    logic              div_ge;

    always_comb begin
        if (width_reg == '0) begin
            w_eff = DW'(1);
        end else if (width_reg > DW'(WIDTH_CAP)) begin
            w_eff = DW'(WIDTH_CAP);
        end else begin
            w_eff = width_reg;
        end
        if (height_reg == '0) begin
            h_eff = DW'(1);
        end else if (height_reg > DW'(aps_pkg::MAX_HEIGHT)) begin
            h_eff = DW'(aps_pkg::MAX_HEIGHT);
        end else begin
            h_eff = height_reg;
        end
        if (pool_reg == '0) begin
            p_eff = PW'(1);
        end else if (pool_reg > PW'(POOL_CAP)) begin
            p_eff = PW'(POOL_CAP);
        end else begin
            p_eff = pool_reg;
        end
    end

    assign p_sq  = (2*PW)'(p_eff) * (2*PW)'(p_eff);
    assign p_ext = QW'(p_eff);
    assign w_ext = QW'(w_eff);
    assign h_ext = QW'(h_eff);

    assign cp_last = (cp_reg == p_eff - 1'b1);
    assign rp_last = (rp_reg == p_eff - 1'b1);

    // A window is used only if it fits whole; the map ends at the last
    // window for which no further whole window follows in either direction.
    assign item_now.in_win   = ((cs_reg + p_ext) <= w_ext) && ((rs_reg + p_ext) <= h_ext);
    assign item_now.first    = (cp_reg == '0) && (rp_reg == '0);
    assign item_now.last     = cp_last && rp_last;
    assign item_now.map_last = cp_last && rp_last
                               && ((cs_reg + p_ext + p_ext) > w_ext)
                               && ((rs_reg + p_ext + p_ext) > h_ext);

    // The first sample of a window starts a fresh sum, so stale entries never matter.
    assign acc_sum = (item_reg.first ? '0 : rd_data_reg) + SUM_W'(sample_reg);
    assign div_ge  = (rem_reg >= dsh_reg);

    assign cfg_hit = cfg_valid && ((cfg_index == aps_pkg::REG_WIDTH)
                                || (cfg_index == aps_pkg::REG_HEIGHT)
                                || (cfg_index == aps_pkg::REG_POOL));

    assign cfg_ready    = 1'b1;
    assign sts.emit     = item_reg.in_win && item_reg.last;
    assign sts.out_free = !m_valid_reg || m_ready;
    assign m_valid      = m_valid_reg;
    assign m_average    = m_average_reg;
    assign m_map_done   = m_map_done_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= aps_pkg::RST_WIDTH;
            height_reg <= aps_pkg::RST_HEIGHT;
            pool_reg   <= aps_pkg::RST_POOL;
        end else if (cfg_valid) begin
            if (cfg_index == aps_pkg::REG_WIDTH) begin
                width_reg <= cfg_data;
            end
            if (cfg_index == aps_pkg::REG_HEIGHT) begin
                height_reg <= cfg_data;
            end
            if (cfg_index == aps_pkg::REG_POOL) begin
                pool_reg <= cfg_data[PW-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_hit) begin
            col_reg <= '0;
            row_reg <= '0;
            cp_reg  <= '0;
            rp_reg  <= '0;
            cs_reg  <= '0;
            rs_reg  <= '0;
            j_reg   <= '0;
        end else if (cmd.take) begin
            if (col_reg == w_eff - 1'b1) begin
                col_reg <= '0;
                cp_reg  <= '0;
                cs_reg  <= '0;
                j_reg   <= '0;
                if (row_reg == h_eff - 1'b1) begin
                    row_reg <= '0;
                    rp_reg  <= '0;
                    rs_reg  <= '0;
                end else begin
                    row_reg <= row_reg + 1'b1;
                    if (rp_last) begin
                        rp_reg <= '0;
                        rs_reg <= rs_reg + p_ext;
                    end else begin
                        rp_reg <= rp_reg + 1'b1;
                    end
                end
            end else begin
                col_reg <= col_reg + 1'b1;
                if (cp_last) begin
                    cp_reg <= '0;
                    cs_reg <= cs_reg + p_ext;
                    j_reg  <= j_reg + 1'b1;
                end else begin
                    cp_reg <= cp_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_reg <= '0;
        end else if (cmd.take) begin
            item_reg <= item_now;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            addr_reg    <= j_reg;
            sample_reg  <= s_sample;
            rd_data_reg <= mem[j_reg];
        end
        if (cmd.accum && item_reg.in_win && !item_reg.last) begin
            mem[addr_reg] <= acc_sum;
        end
    end

    // Restoring division, one quotient bit per cycle, most significant first.
    always_ff @(posedge aclk) begin
        if (cmd.accum && sts.emit) begin
            rem_reg  <= REM_W'(acc_sum);
            dsh_reg  <= REM_W'(DIV_W'(p_sq)) << (SW - 1);
            done_reg <= item_reg.map_last;
        end else if (cmd.div_step) begin
            rem_reg <= div_ge ? (rem_reg - dsh_reg) : rem_reg;
            dsh_reg <= dsh_reg >> 1;
            quo_reg <= {quo_reg[SW-2:0], div_ge};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_average_reg  <= quo_reg;
            m_map_done_reg <= done_reg;
        end
    end

endmodule

// ===== hw/rtl/average_pooling_stream.sv =====
// Each accepted sample passes the memory read, then accumulate; no new sample is taken
// until it is through. A sample that completes a window then runs the 16-step serial
// divider and waits in the finish state until the output register can take its average.
// The output register lets the next sample in while an average waits to be taken.
// Reset (aresetn low, synchronous) restores the default size and pool and restarts the map.
module average_pooling_stream #(
    parameter int MAX_WIDTH = aps_pkg::DEF_MAX_WIDTH,
    parameter int MAX_POOL  = aps_pkg::DEF_MAX_POOL
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [aps_pkg::SAMPLE_W-1:0]    s_sample,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [aps_pkg::SAMPLE_W-1:0]    m_average,
    output logic                            m_map_done,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [aps_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [aps_pkg::DIM_W-1:0]       cfg_data
);

    aps_pkg::aps_cmd_t cmd;
    aps_pkg::aps_sts_t sts;

    aps_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    aps_datapath #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_POOL  (MAX_POOL)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_sample   (s_sample),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_average  (m_average),
        .m_map_done (m_map_done),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cmd        (cmd),
        .sts        (sts)
    );

endmodule

// ===== hw/rtl/aps_checker.sv =====
module aps_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_valid,
    input logic                         s_ready,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic [aps_pkg::SAMPLE_W-1:0] m_average,
    input logic                         m_map_done
);

    // Only one request is in work at a time.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input taken while a request is still in work");

    // A fresh average must follow its completing request.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready, 20))
        else $error("average appeared without a matching request");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid)
        else $error("result dropped before it was taken");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> ($stable(m_average) && $stable(m_map_done)))
        else $error("stalled result changed");

endmodule

bind average_pooling_stream aps_checker u_aps_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .s_valid    (s_valid),
    .s_ready    (s_ready),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_average  (m_average),
    .m_map_done (m_map_done)
);
